### rtl/assert_macros.svh
// Assertion macros shared by the receiver RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, expr, msg)

`define ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/xcr_pkg.sv
// Constants, types and the CRC-16 step for the XMODEM-CRC receiver.
package xcr_pkg;

    localparam int LONG_BLOCK_BYTES_DEF  = 1024;
    localparam int SHORT_BLOCK_BYTES_DEF = 128;
    localparam int RES_QUEUE_DEPTH       = 4;

    localparam logic [31:0] BASE_ADDR_RESET = 32'h0800_2000;
    localparam logic [15:0] CRC_POLY        = 16'h1021;

    localparam logic [7:0] HDR_SOH = 8'h01;
    localparam logic [7:0] HDR_STX = 8'h02;
    localparam logic [7:0] HDR_EOT = 8'h04;
    localparam logic [7:0] RSP_ACK = 8'h06;
    localparam logic [7:0] RSP_NAK = 8'h15;
    localparam logic [7:0] HDR_CAN = 8'h18;
    localparam logic [7:0] RSP_C   = 8'h43;
    localparam logic [7:0] BLK_SUM = 8'hFF;

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] STATUS_RUN    = 2'd0;
    localparam logic [1:0] STATUS_DONE   = 2'd1;
    localparam logic [1:0] STATUS_CANCEL = 2'd2;

    localparam logic REG_BASE_ADDR = 1'b0;

    typedef enum logic [3:0] {
        PH_WAIT   = 4'b0001,
        PH_BLOCK  = 4'b0010,
        PH_DONE   = 4'b0100,
        PH_CANCEL = 4'b1000
    } phase_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/xcr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module xcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/xcr_res_queue.sv
// Small result queue: takes up to two entries a cycle, hands out one.
module xcr_res_queue #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push0,
    input  logic                       push1,
    input  logic [WIDTH-1:0]           d0,
    input  logic [WIDTH-1:0]           d1,
    input  logic                       pop,
    output logic [WIDTH-1:0]           q,
    output logic                       not_empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    tail_reg, tail_next, tail_inc;
    logic [CW-1:0]    count_reg, count_next;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign tail_inc = ptr_inc(tail_reg);

    always_comb
    begin
        head_next  = pop ? ptr_inc(head_reg) : head_reg;
        tail_next  = tail_reg;
        if (push0)
        begin
            tail_next = push1 ? ptr_inc(tail_inc) : tail_inc;
        end
        count_next = count_reg + CW'(push0) + CW'(push0 & push1) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            entry_reg[tail_reg] <= d0;
        end
        if (push0 && push1)
        begin
            entry_reg[tail_inc] <= d1;
        end
    end

    assign q         = entry_reg[head_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

### rtl/xmodem_crc_receiver.sv
// XMODEM-CRC receiver for 128-byte and 1K blocks.
//
// Input channel (in_valid/in_ready): one transaction per command, a received
// serial byte, a one-second timeout tick or a read of the payload buffer.
// Output channel (out_valid/out_ready): zero, one or two result transactions
// per command, in order; last marks the final one of a command. A CAN header
// gives two transactions, a silent byte or tick gives none.
// Results are registered in the command stage, which reads the buffer, then
// queued. Throughput: one command per cycle while out_ready stays high and no
// command gives two results; in_ready drops only when the four-entry result
// queue cannot take what is in flight. Each byte updates CRC and block state
// in the cycle it is taken. Committed payload stays in the buffer until the
// next block overwrites it; read it back with read commands before
// acknowledging upstream. Reset clears the protocol state, empties the queue
// and loads base_addr and the write address with 0x08002000; the buffer is
// not cleared. A stalled receiver holds the head result; commands keep
// flowing only while the queue can hold all results in flight plus two. The
// user must write base_addr over APB only while idle; it is not enforced.
`include "assert_macros.svh"

module xmodem_crc_receiver
    import xcr_pkg::*;
#(
    parameter int LONG_BLOCK_BYTES  = LONG_BLOCK_BYTES_DEF,
    parameter int SHORT_BLOCK_BYTES = SHORT_BLOCK_BYTES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            cmd,
    input  logic [7:0]                            rx_byte,
    input  logic [9:0]                            read_index,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  tx_valid,
    output logic [7:0]                            tx_byte,
    output logic                                  commit_valid,
    output logic [31:0]                           commit_addr,
    output logic [$clog2(LONG_BLOCK_BYTES+1)-1:0] commit_len,
    output logic [7:0]                            rd_data,
    output logic [1:0]                            status,
    output logic                                  last
);

    localparam int AW  = $clog2(LONG_BLOCK_BYTES);
    localparam int BPW = $clog2(LONG_BLOCK_BYTES + 4);
    localparam int CLW = $clog2(LONG_BLOCK_BYTES + 1);
    localparam int QCW = $clog2(RES_QUEUE_DEPTH + 1);

    typedef struct packed {
        logic             tx_valid;
        logic [7:0]       tx_byte;
        logic             commit_valid;
        logic [31:0]      commit_addr;
        logic [CLW-1:0]   commit_len;
        logic [7:0]       rd_data;
        logic [1:0]       status;
        logic             last;
    } res_t;

    localparam int RW = $bits(res_t);

    phase_t           phase_reg, phase_next;
    logic [BPW-1:0]   byte_pos_reg, byte_pos_next;
    logic             long_block_reg, long_block_next;
    logic [7:0]       block_num_reg, block_num_next;
    logic [7:0]       block_num_inv_reg, block_num_inv_next;
    logic [15:0]      crc_acc_reg, crc_acc_next;
    logic [7:0]       crc_rx_high_reg, crc_rx_high_next;
    logic [7:0]       expected_block_reg, expected_block_next;
    logic [31:0]      write_addr_reg, write_addr_next;
    logic [31:0]      base_addr_reg, base_addr_next;

    logic             s1_valid_reg, s1_valid_next;
    logic             s1_two_reg, s1_two_next;
    logic             s1_read_reg, s1_read_next;
    res_t             s1_res_reg, s1_res_next;

    logic             accept;
    logic             cfg_we;
    logic [BPW-1:0]   blk_size;
    logic [BPW-1:0]   size_p2;
    logic [BPW-1:0]   buf_idx;
    logic             ram_we;
    logic [AW-1:0]    ram_raddr;
    logic [7:0]       ram_q;
    logic             rd_out_range;

    res_t             push_d0, push_d1, head;
    logic [RW-1:0]    q_data;
    logic             q_not_empty;
    logic [QCW-1:0]   q_count;
    logic [QCW:0]     in_flight;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_BASE_ADDR) ? base_addr_reg : 32'h0;

    assign accept   = in_valid & in_ready;
    assign blk_size = long_block_reg ? BPW'(LONG_BLOCK_BYTES) : BPW'(SHORT_BLOCK_BYTES);
    assign size_p2  = blk_size + BPW'(2);
    assign buf_idx  = byte_pos_reg - BPW'(2);

    assign ram_raddr    = AW'(32'(read_index));
    assign rd_out_range = (32'(read_index) >= 32'(LONG_BLOCK_BYTES));

    always_comb
    begin
        phase_next          = phase_reg;
        byte_pos_next       = byte_pos_reg;
        long_block_next     = long_block_reg;
        block_num_next      = block_num_reg;
        block_num_inv_next  = block_num_inv_reg;
        crc_acc_next        = crc_acc_reg;
        crc_rx_high_next    = crc_rx_high_reg;
        expected_block_next = expected_block_reg;
        write_addr_next     = write_addr_reg;
        base_addr_next      = base_addr_reg;
        ram_we              = 1'b0;
        s1_valid_next       = 1'b0;
        s1_two_next         = 1'b0;
        s1_read_next        = 1'b0;
        s1_res_next         = '0;

        if (accept)
        begin
            if (cmd == CMD_READ)
            begin
                s1_valid_next = 1'b1;
                s1_read_next  = !rd_out_range;
            end
            else if (cmd == CMD_TICK)
            begin
                unique case (phase_reg)
                    PH_BLOCK:
                    begin
                        phase_next           = PH_WAIT;
                        byte_pos_next        = '0;
                        s1_valid_next        = 1'b1;
                        s1_res_next.tx_valid = 1'b1;
                        s1_res_next.tx_byte  = RSP_NAK;
                    end
                    PH_WAIT:
                    begin
                        s1_valid_next        = 1'b1;
                        s1_res_next.tx_valid = 1'b1;
                        s1_res_next.tx_byte  = RSP_C;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd == CMD_BYTE)
            begin
                unique case (phase_reg)
                    PH_WAIT:
                    begin
                        if (rx_byte == HDR_SOH || rx_byte == HDR_STX)
                        begin
                            long_block_next = (rx_byte == HDR_STX);
                            byte_pos_next   = '0;
                            crc_acc_next    = '0;
                            phase_next      = PH_BLOCK;
                        end
                        else if (rx_byte == HDR_EOT)
                        begin
                            phase_next           = PH_DONE;
                            s1_valid_next        = 1'b1;
                            s1_res_next.tx_valid = 1'b1;
                            s1_res_next.tx_byte  = RSP_ACK;
                        end
                        else if (rx_byte == HDR_CAN)
                        begin
                            phase_next           = PH_CANCEL;
                            s1_valid_next        = 1'b1;
                            s1_two_next          = 1'b1;
                            s1_res_next.tx_valid = 1'b1;
                            s1_res_next.tx_byte  = HDR_CAN;
                        end
                    end
                    PH_BLOCK:
                    begin
                        byte_pos_next = byte_pos_reg + 1'b1;
                        if (byte_pos_reg == BPW'(0))
                        begin
                            block_num_next = rx_byte;
                        end
                        else if (byte_pos_reg == BPW'(1))
                        begin
                            block_num_inv_next = rx_byte;
                        end
                        else if (byte_pos_reg < size_p2)
                        begin
                            ram_we       = (buf_idx < BPW'(LONG_BLOCK_BYTES));
                            crc_acc_next = crc16_byte(crc_acc_reg, rx_byte);
                        end
                        else if (byte_pos_reg == size_p2)
                        begin
                            crc_rx_high_next = rx_byte;
                        end
                        else
                        begin
                            phase_next           = PH_WAIT;
                            byte_pos_next        = '0;
                            s1_valid_next        = 1'b1;
                            s1_res_next.tx_valid = 1'b1;
                            s1_res_next.tx_byte  = RSP_NAK;
                            if (8'(block_num_reg + block_num_inv_reg) == BLK_SUM
                                && {crc_rx_high_reg, rx_byte} == crc_acc_reg)
                            begin
                                if (block_num_reg == expected_block_reg)
                                begin
                                    s1_res_next.tx_byte      = RSP_ACK;
                                    s1_res_next.commit_valid = 1'b1;
                                    s1_res_next.commit_addr  = write_addr_reg;
                                    s1_res_next.commit_len   = CLW'(blk_size);
                                    write_addr_next     = write_addr_reg + 32'(blk_size);
                                    expected_block_next = expected_block_reg + 8'd1;
                                end
                                else if (block_num_reg == expected_block_reg - 8'd1)
                                begin
                                    s1_res_next.tx_byte = RSP_ACK;
                                end
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        unique case (phase_next)
            PH_DONE:   s1_res_next.status = STATUS_DONE;
            PH_CANCEL: s1_res_next.status = STATUS_CANCEL;
            default:   s1_res_next.status = STATUS_RUN;
        endcase

        if (cfg_we && paddr[2] == REG_BASE_ADDR)
        begin
            base_addr_next  = pwdata;
            write_addr_next = pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_WAIT;
            byte_pos_reg       <= '0;
            long_block_reg     <= 1'b0;
            block_num_reg      <= '0;
            block_num_inv_reg  <= '0;
            crc_acc_reg        <= '0;
            crc_rx_high_reg    <= '0;
            expected_block_reg <= 8'd1;
            write_addr_reg     <= BASE_ADDR_RESET;
            base_addr_reg      <= BASE_ADDR_RESET;
            s1_valid_reg       <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            byte_pos_reg       <= byte_pos_next;
            long_block_reg     <= long_block_next;
            block_num_reg      <= block_num_next;
            block_num_inv_reg  <= block_num_inv_next;
            crc_acc_reg        <= crc_acc_next;
            crc_rx_high_reg    <= crc_rx_high_next;
            expected_block_reg <= expected_block_next;
            write_addr_reg     <= write_addr_next;
            base_addr_reg      <= base_addr_next;
            s1_valid_reg       <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_two_reg  <= s1_two_next;
        s1_read_reg <= s1_read_next;
        s1_res_reg  <= s1_res_next;
    end

    xcr_ram #(
        .WIDTH (8),
        .DEPTH (LONG_BLOCK_BYTES)
    ) u_payload_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(buf_idx)),
        .wdata (rx_byte),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    always_comb
    begin
        push_d0         = s1_res_reg;
        push_d0.rd_data = s1_read_reg ? ram_q : 8'h00;
        push_d0.last    = !s1_two_reg;
        push_d1         = push_d0;
        push_d1.last    = 1'b1;
    end

    assign in_flight = {1'b0, q_count}
                     + (s1_valid_reg ? (s1_two_reg ? (QCW+1)'(2) : (QCW+1)'(1)) : '0)
                     + (QCW+1)'(2);
    assign in_ready  = (in_flight <= (QCW+1)'(RES_QUEUE_DEPTH));

    xcr_res_queue #(
        .WIDTH (RW),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push0     (s1_valid_reg),
        .push1     (s1_valid_reg & s1_two_reg),
        .d0        (push_d0),
        .d1        (push_d1),
        .pop       (q_not_empty & out_ready),
        .q         (q_data),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign head         = res_t'(q_data);
    assign out_valid    = q_not_empty;
    assign tx_valid     = head.tx_valid;
    assign tx_byte      = head.tx_byte;
    assign commit_valid = head.commit_valid;
    assign commit_addr  = head.commit_addr;
    assign commit_len   = head.commit_len;
    assign rd_data      = head.rd_data;
    assign status       = head.status;
    assign last         = head.last;

    `ASSERT_ALWAYS(a_queue_bound, q_count <= QCW'(RES_QUEUE_DEPTH), "result queue overrun")

    `ASSERT_ALWAYS(a_commit_acked, !(out_valid && commit_valid) || tx_byte == RSP_ACK, "commit without ACK")

    `ASSERT_NEXT(a_silent_after_end, accept && cmd != CMD_READ && (phase_reg == PH_DONE || phase_reg == PH_CANCEL), !s1_valid_reg, "result after transfer end")

endmodule
